[src/psfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime sieve filter chain package
// Transaction types and the status bundle of the remainder unit.
// ----------------------------------------------------------------------------
package psfc_pkg;

	typedef struct packed {
		logic [15:0] candidate;
		logic        is_last;
	} item_t;

	typedef struct packed {
		logic [15:0] prime_value;
		logic        found_prime;
		logic        overflow;
		logic        end_of_run;
	} result_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} div_status_t;

endpackage

[src/psfc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module psfc_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/psfc_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module psfc_mod #(
	parameter int W = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [W-1:0]         dividend,
	input  logic [W-1:0]         divisor,
	output psfc_pkg::div_status_t status
);
	import psfc_pkg::*;

	localparam int CNTW = $clog2(W + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [W-1:0]    dvd_q;
	logic [W-1:0]    dvs_q;
	logic [W-1:0]    rem_q;
	logic [W:0]      shifted;
	logic            fits;

	assign shifted = {rem_q, dvd_q[W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			rem_q <= fits ? W'(shifted - {1'b0, dvs_q}) : shifted[W-1:0];
		end
	end

	assign status.done     = done_q;
	assign status.rem_zero = (rem_q == '0);

endmodule

[src/prime_sieve_filter_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime sieve filter chain
// Tests candidates against the stored primes and keeps the new ones.
// ----------------------------------------------------------------------------
// One candidate is handled at a time. Its stored primes are read one by one
// from a single RAM and each one is checked by a bit-serial remainder unit,
// and a composite stops at the first prime that divides it. The filled cells
// form a prefix of the chain and are tracked by a fill count, so no clearing
// pass is needed after reset or after the last candidate of a run. A finished
// result sits in an output register, so the next candidate is taken while the
// result still waits.
module prime_sieve_filter_chain #(
	parameter int NUM_CELLS  = 64,
	parameter int VALUE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  psfc_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output psfc_pkg::result_t result
);
	import psfc_pkg::*;

	localparam int AW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int CW = $clog2(NUM_CELLS + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_LOAD   = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]            state_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q;
	logic [CW-1:0]         idx_next;
	logic [VALUE_BITS-1:0] cand_q;
	logic [VALUE_BITS-1:0] cand_w;
	logic                  last_q;
	logic                  prime_q;
	logic                  result_valid_q;
	result_t               result_q;
	logic                  accept;
	logic                  full;
	logic                  slot_free;
	logic                  finish_go;
	logic                  store;
	logic [VALUE_BITS-1:0] rd_data;
	div_status_t           div_status;

	assign cand_w    = VALUE_BITS'(item.candidate);
	assign accept    = item_valid && (state_q == ST_IDLE);
	assign full      = (count_q == CW'(NUM_CELLS));
	assign idx_next  = idx_q + CW'(1);
	assign slot_free = !result_valid_q || !result_stall;
	assign finish_go = (state_q == ST_FINISH) && slot_free;
	assign store     = finish_go && prime_q && !full;

	// Writes happen only in the finish step and reads only while testing,
	// so the sequencing keeps a read and a write of the same cell apart.
	psfc_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (NUM_CELLS)
	) u_ram (
		.clk   (clk),
		.we    (store),
		.waddr (count_q[AW-1:0]),
		.wdata (cand_q),
		.re    (state_q == ST_READ),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	psfc_mod #(
		.W (VALUE_BITS)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_LOAD),
		.dividend (cand_q),
		.divisor  (rd_data),
		.status   (div_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cand_w < VALUE_BITS'(2) || count_q == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_status.done) begin
						if (div_status.rem_zero || idx_next == count_q) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							count_q <= '0;
						end else if (store) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q  <= cand_w;
			last_q  <= item.is_last;
			idx_q   <= '0;
			prime_q <= (cand_w >= VALUE_BITS'(2));
		end else if (state_q == ST_DIV && div_status.done) begin
			if (div_status.rem_zero) begin
				prime_q <= 1'b0;
			end
			idx_q <= idx_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (finish_go && (prime_q || last_q)) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go && (prime_q || last_q)) begin
			result_q.prime_value <= prime_q ? 16'(cand_q) : 16'd0;
			result_q.found_prime <= prime_q;
			result_q.overflow    <= prime_q && full;
			result_q.end_of_run  <= last_q;
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[src/psfc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime sieve filter chain checker
// Port-level assertions, attached to the top level by a bind.
// ----------------------------------------------------------------------------
module psfc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input psfc_pkg::result_t result
);
	import psfc_pkg::*;

	// A stalled result transaction must stay offered.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// The block works on one candidate at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("second candidate taken while busy");

	// A result without a prime only marks the end of a run.
	a_no_prime_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found_prime |->
			result.end_of_run && !result.overflow && result.prime_value == 16'd0)
		else $error("empty result that is not an end marker");

	// Overflow is only reported together with a prime.
	a_overflow_prime: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflow |-> result.found_prime && result.prime_value >= 16'd2)
		else $error("overflow without a prime");

endmodule

bind prime_sieve_filter_chain psfc_checker u_psfc_checker (.*);
